FILE: src/per_flow_traffic_statistics_assert.svh
// Assertion macros used by the checker file.
`ifndef PER_FLOW_TRAFFIC_STATISTICS_ASSERT_SVH
`define PER_FLOW_TRAFFIC_STATISTICS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PFTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("per-flow statistics check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PFTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("per-flow statistics check failed");

`endif

FILE: src/pfts_pkg.sv
package pfts_pkg;

  localparam int FLOW_SLOTS = 16;
  localparam int SLOT_W     = 4;

  localparam int MUL_STEPS = 8;
  localparam int DIV_STEPS = 48;
  localparam int NUM_W     = 160;
  localparam int ACC_W     = 192;
  localparam int CNT_W     = 6;

  localparam logic [1:0] FUNC_TX    = 2'd0;
  localparam logic [1:0] FUNC_RX    = 2'd1;
  localparam logic [1:0] FUNC_SMP   = 2'd2;
  localparam logic [1:0] FUNC_CLOSE = 2'd3;

  localparam logic [2:0] JOB_RATE  = 3'd0;
  localparam logic [2:0] JOB_CA    = 3'd1;
  localparam logic [2:0] JOB_CS    = 3'd2;
  localparam logic [2:0] JOB_MSIZE = 3'd3;
  localparam logic [2:0] JOB_CWND  = 3'd4;
  localparam logic [2:0] JOB_RTT   = 3'd5;
  localparam logic [2:0] JOB_LAT   = 3'd6;

  localparam logic [63:0] RATE_SCALE = 64'd524288000;
  localparam logic [63:0] NS_PER_MS  = 64'd1000000;
  localparam logic [39:0] WINDOW_RST = 40'd100000000;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GAP, OP_SQR, OP_WB, OP_MSET, OP_MSTEP, OP_MDRAIN,
    OP_MSAVE, OP_DSET, OP_DSTEP, OP_DSTORE, OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GAP, ST_SQR, ST_WB, ST_MSET, ST_MSTEP, ST_MDRAIN, ST_MSAVE,
    ST_DSET, ST_DCHK, ST_DSTEP, ST_DSTORE, ST_EMIT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] job;
    logic [1:0] phase;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic div_short;
  } sts_t;

endpackage

FILE: src/pfts_ctrl.sv
module pfts_ctrl import pfts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] func_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e           state_q, state_d;
  logic [2:0]       job_q, job_d;
  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       last_phase;

  assign last_phase = (job_q == JOB_CA || job_q == JOB_CS) ? 2'd3 : 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_RATE;
      phase_q <= 2'd0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (func_i)
            FUNC_TX:  state_d = ST_GAP;
            FUNC_RX:  state_d = ST_WB;
            FUNC_SMP: state_d = ST_WB;
            default: begin
              state_d = ST_MSET;
              job_d   = JOB_RATE;
              phase_d = 2'd0;
            end
          endcase
        end
      end
      ST_GAP: state_d = ST_SQR;
      ST_SQR: state_d = ST_WB;
      ST_WB:  state_d = ST_IDLE;
      ST_MSET: begin
        cnt_d   = '0;
        state_d = ST_MSTEP;
      end
      ST_MSTEP: begin
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          state_d = ST_MDRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MDRAIN: state_d = ST_MSAVE;
      ST_MSAVE: begin
        if (phase_q == last_phase) begin
          state_d = ST_DSET;
        end else begin
          phase_d = phase_q + 1'b1;
          state_d = ST_MSET;
        end
      end
      ST_DSET: state_d = ST_DCHK;
      ST_DCHK: begin
        cnt_d   = '0;
        state_d = sts_i.div_short ? ST_DSTORE : ST_DSTEP;
      end
      ST_DSTEP: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_DSTORE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DSTORE: begin
        if (job_q == JOB_LAT) begin
          state_d = ST_EMIT;
        end else begin
          job_d   = job_q + 1'b1;
          phase_d = 2'd0;
          state_d = ST_MSET;
        end
      end
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.job   = job_q;
    cmd_o.phase = phase_q;
    cmd_o.step  = cnt_q[2:0];
    case (state_q)
      ST_IDLE:   cmd_o.op = start_i ? OP_LOAD : OP_NONE;
      ST_GAP:    cmd_o.op = OP_GAP;
      ST_SQR:    cmd_o.op = OP_SQR;
      ST_WB:     cmd_o.op = OP_WB;
      ST_MSET:   cmd_o.op = OP_MSET;
      ST_MSTEP:  cmd_o.op = OP_MSTEP;
      ST_MDRAIN: cmd_o.op = OP_MDRAIN;
      ST_MSAVE:  cmd_o.op = OP_MSAVE;
      ST_DSET:   cmd_o.op = OP_DSET;
      ST_DSTEP:  cmd_o.op = OP_DSTEP;
      ST_DSTORE: cmd_o.op = OP_DSTORE;
      ST_EMIT:   cmd_o.op = OP_EMIT;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: src/pfts_dp.sv
module pfts_dp import pfts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic [39:0] cfg_wdata_i,
  input  logic [1:0]  func_i,
  input  logic [3:0]  flow_slot_i,
  input  logic [62:0] now_ns_i,
  input  logic [15:0] packet_size_i,
  input  logic [39:0] latency_ns_i,
  input  logic [31:0] cwnd_i,
  input  logic [39:0] rtt_ns_i,
  output logic        done_o,
  output logic        reportable_o,
  output logic [47:0] mean_datarate_o,
  output logic [31:0] ca_sqr_o,
  output logic [31:0] cs_sqr_o,
  output logic [23:0] mean_packet_size_o,
  output logic [31:0] tx_packets_o,
  output logic [47:0] tx_bytes_o,
  output logic [31:0] rx_packets_o,
  output logic [47:0] rx_bytes_o,
  output logic [39:0] mean_cwnd_o,
  output logic [39:0] mean_rtt_o,
  output logic [39:0] mean_latency_o
);

  typedef struct packed {
    logic [47:0] size_sum;
    logic [63:0] size_sq;
    logic [31:0] arr_cnt;
    logic [63:0] gap_sum;
    logic [63:0] gap_sq;
    logic [62:0] last_ns;
    logic [63:0] lat_sum;
    logic [31:0] lat_cnt;
    logic [47:0] rx_bytes;
    logic [31:0] rx_cnt;
    logic [63:0] win_sum;
    logic [63:0] rtt_sum;
    logic [31:0] smp_cnt;
  } ent_t;

  function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [31:0] inc_sat32(logic [31:0] a);
    return (&a) ? a : a + 32'd1;
  endfunction

  // flow table: valid bit per slot stands for the cleared state
  ent_t                  tab_q [FLOW_SLOTS];
  logic [FLOW_SLOTS-1:0] valid_q;
  logic [39:0]           window_q;
  logic                  done_q;

  ent_t        ent_q, ent_wb;
  logic [1:0]  func_q;
  logic [SLOT_W-1:0] slot_q;
  logic [62:0] now_q, gap_q;
  logic [16:0] sz_q;
  logic [39:0] lat_q, rtt_q;
  logic [31:0] cwnd_q;
  logic [63:0] gsq_q;
  logic [33:0] szsq_q;

  // shared multiplier and divider
  logic [127:0]      a_q, mul_a, x_q, ss_q;
  logic [63:0]       b_q, mul_b, mp_q;
  logic [2:0]        sh_q;
  logic [ACC_W-1:0]  acc_q, addend;
  logic [NUM_W-1:0]  num_q, den_q, rem_q, rem_sub;
  logic [NUM_W:0]    rem_sh;
  logic [47:0]       low_q, quot_q, fin;
  logic              zero_q, sat_q, ge, cv;
  logic [31:0]       nn;
  logic [63:0]       s_sel, q_sel;

  logic [47:0] rate_q;
  logic [31:0] ca_q, cs_q;
  logic [23:0] msize_q;
  logic [39:0] mcwnd_q, mrtt_q, mlat_q;

  // write-back value of the current entry
  always_comb begin
    logic [31:0] cnt_new;
    cnt_new = inc_sat32(ent_q.arr_cnt);
    ent_wb  = ent_q;
    case (func_q)
      FUNC_TX: begin
        ent_wb.size_sum = add_sat48(ent_q.size_sum, {31'd0, sz_q});
        ent_wb.size_sq  = add_sat64(ent_q.size_sq, {30'd0, szsq_q});
        ent_wb.arr_cnt  = cnt_new;
        if (cnt_new > 32'd1) begin
          ent_wb.gap_sum = add_sat64(ent_q.gap_sum, {1'b0, gap_q});
          ent_wb.gap_sq  = add_sat64(ent_q.gap_sq, gsq_q);
        end
        ent_wb.last_ns = now_q;
      end
      FUNC_RX: begin
        ent_wb.lat_sum  = add_sat64(ent_q.lat_sum, {24'd0, lat_q});
        ent_wb.lat_cnt  = inc_sat32(ent_q.lat_cnt);
        ent_wb.rx_bytes = add_sat48(ent_q.rx_bytes, {31'd0, sz_q});
        ent_wb.rx_cnt   = inc_sat32(ent_q.rx_cnt);
      end
      FUNC_SMP: begin
        ent_wb.win_sum = add_sat64(ent_q.win_sum, {32'd0, cwnd_q});
        ent_wb.rtt_sum = add_sat64(ent_q.rtt_sum, {24'd0, rtt_q});
        ent_wb.smp_cnt = inc_sat32(ent_q.smp_cnt);
      end
      default: ent_wb = ent_q;
    endcase
  end

  // operand selection for the squared-CV and mean jobs
  assign cv    = (cmd_i.job == JOB_CA) || (cmd_i.job == JOB_CS);
  assign nn    = (cmd_i.job == JOB_CA) ?
                 ((ent_q.arr_cnt == 32'd0) ? 32'd0 : ent_q.arr_cnt - 32'd1) :
                 ent_q.arr_cnt;
  assign s_sel = (cmd_i.job == JOB_CA) ? ent_q.gap_sum : {16'd0, ent_q.size_sum};
  assign q_sel = (cmd_i.job == JOB_CA) ? ent_q.gap_sq : ent_q.size_sq;

  always_comb begin
    logic p0;
    p0 = (cmd_i.phase == 2'd0);
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.job)
      JOB_RATE: begin
        mul_a = p0 ? {80'd0, ent_q.size_sum} : {88'd0, window_q};
        mul_b = p0 ? RATE_SCALE : 64'd1;
      end
      JOB_CA, JOB_CS: begin
        case (cmd_i.phase)
          2'd0: begin mul_a = {64'd0, q_sel}; mul_b = {32'd0, nn}; end
          2'd1: begin mul_a = {64'd0, s_sel}; mul_b = s_sel; end
          2'd2: begin mul_a = x_q - ss_q;     mul_b = {32'd0, nn}; end
          default: begin mul_a = ss_q;        mul_b = {32'd0, nn - 32'd1}; end
        endcase
      end
      JOB_MSIZE: begin
        mul_a = p0 ? {80'd0, ent_q.size_sum} : {96'd0, ent_q.arr_cnt};
        mul_b = p0 ? 64'd256 : 64'd1;
      end
      JOB_CWND: begin
        mul_a = p0 ? {64'd0, ent_q.win_sum} : {96'd0, ent_q.smp_cnt};
        mul_b = p0 ? 64'd256 : 64'd1;
      end
      JOB_RTT: begin
        mul_a = p0 ? {64'd0, ent_q.rtt_sum} : {96'd0, ent_q.smp_cnt};
        mul_b = p0 ? 64'd65536 : NS_PER_MS;
      end
      JOB_LAT: begin
        mul_a = p0 ? {64'd0, ent_q.lat_sum} : {96'd0, ent_q.lat_cnt};
        mul_b = p0 ? 64'd65536 : NS_PER_MS;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign addend  = {128'd0, mp_q} << {sh_q, 5'd0};
  assign rem_sh  = {rem_q, low_q[47]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = NUM_W'(rem_sh - {1'b0, den_q});
  assign fin     = zero_q ? 48'd0 : (sat_q ? '1 : quot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      window_q <= WINDOW_RST;
      done_q   <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == OP_EMIT);
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_WB) begin
        valid_q[slot_q] <= 1'b1;
      end else if (cmd_i.op == OP_EMIT) begin
        valid_q[slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WB) begin
      tab_q[slot_q] <= ent_wb;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q <= func_i;
        slot_q <= flow_slot_i;
        now_q  <= now_ns_i;
        sz_q   <= {1'b0, packet_size_i} + 17'd2;
        lat_q  <= latency_ns_i;
        cwnd_q <= cwnd_i;
        rtt_q  <= rtt_ns_i;
        ent_q  <= valid_q[flow_slot_i] ? tab_q[flow_slot_i] : '0;
      end
      OP_GAP: gap_q <= (now_q >= ent_q.last_ns) ? now_q - ent_q.last_ns : '0;
      OP_SQR: begin
        gsq_q  <= (|gap_q[62:32]) ? '1 : gap_q[31:0] * gap_q[31:0];
        szsq_q <= {17'd0, sz_q} * {17'd0, sz_q};
      end
      OP_MSET: begin
        a_q   <= mul_a;
        b_q   <= mul_b;
        acc_q <= '0;
        mp_q  <= '0;
        sh_q  <= '0;
      end
      OP_MSTEP: begin
        acc_q <= acc_q + addend;
        mp_q  <= a_q[{cmd_i.step[1:0], 5'd0} +: 32] * b_q[{cmd_i.step[2], 5'd0} +: 32];
        sh_q  <= {1'b0, cmd_i.step[1:0]} + {2'd0, cmd_i.step[2]};
      end
      OP_MDRAIN: acc_q <= acc_q + addend;
      OP_MSAVE: begin
        if (cv) begin
          case (cmd_i.phase)
            2'd0:    x_q   <= acc_q[127:0];
            2'd1:    ss_q  <= acc_q[127:0];
            2'd2:    num_q <= {acc_q[NUM_W-17:0], 16'd0};
            default: den_q <= acc_q[NUM_W-1:0];
          endcase
        end else if (cmd_i.phase == 2'd0) begin
          num_q <= acc_q[NUM_W-1:0];
        end else begin
          den_q <= acc_q[NUM_W-1:0];
        end
      end
      OP_DSET: begin
        // short paths: zero divisor or degenerate CV give 0, big quotient saturates
        zero_q <= (den_q == '0) ||
                  (cv && ((nn < 32'd2) || (s_sel == '0) || (x_q <= ss_q)));
        sat_q  <= {48'd0, num_q[NUM_W-1:48]} >= den_q;
        rem_q  <= {48'd0, num_q[NUM_W-1:48]};
        low_q  <= num_q[47:0];
        quot_q <= '0;
      end
      OP_DSTEP: begin
        rem_q  <= ge ? rem_sub : rem_sh[NUM_W-1:0];
        quot_q <= {quot_q[46:0], ge};
        low_q  <= {low_q[46:0], 1'b0};
      end
      OP_DSTORE: begin
        case (cmd_i.job)
          JOB_RATE:  rate_q  <= fin;
          JOB_CA:    ca_q    <= (|fin[47:32]) ? '1 : fin[31:0];
          JOB_CS:    cs_q    <= (|fin[47:32]) ? '1 : fin[31:0];
          JOB_MSIZE: msize_q <= (|fin[47:24]) ? '1 : fin[23:0];
          JOB_CWND:  mcwnd_q <= (|fin[47:40]) ? '1 : fin[39:0];
          JOB_RTT:   mrtt_q  <= (|fin[47:40]) ? '1 : fin[39:0];
          default:   mlat_q  <= (|fin[47:40]) ? '1 : fin[39:0];
        endcase
      end
      default: ;
    endcase
  end

  assign sts_o.div_short = zero_q | sat_q;

  assign done_o             = done_q;
  assign reportable_o       = (ent_q.arr_cnt > 32'd1);
  assign mean_datarate_o    = rate_q;
  assign ca_sqr_o           = ca_q;
  assign cs_sqr_o           = cs_q;
  assign mean_packet_size_o = msize_q;
  assign tx_packets_o       = ent_q.arr_cnt;
  assign tx_bytes_o         = ent_q.size_sum;
  assign rx_packets_o       = ent_q.rx_cnt;
  assign rx_bytes_o         = ent_q.rx_bytes;
  assign mean_cwnd_o        = mcwnd_q;
  assign mean_rtt_o         = mrtt_q;
  assign mean_latency_o     = mlat_q;

endmodule

FILE: src/per_flow_traffic_statistics.sv
// Per-flow traffic statistics: 16 flow slots of window accumulators.
// Command channel: raise start_i with func_i, flow_slot_i and the event
// fields; the word is taken at a rising edge with start_i high and busy_o low.
// Transmit events go through read, gap, squares and write back; receive
// and sample events through read and write back. Busy stays high until
// the slot is written. A close event walks seven jobs through one shared
// 32x32 multiplier (load, eight partial products, drain and save per wide
// product) and one restoring divider (one quotient bit per cycle, 48 bits);
// a quotient that is trivially 0 or saturated skips the divider steps.
// The result word appears for exactly one cycle with done_o high,
// in the cycle busy_o drops; the receiver cannot stall, so sample it then.
// Close clears the slot. Configuration: cfg_we_i writes window_ns (the data
// rate divisor); the user must do this while the block is idle, which the
// block does not enforce. Reset clears every slot through per-slot valid
// bits at once and sets the window to 100 ms; no clearing sweep is needed.
module per_flow_traffic_statistics import pfts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [39:0] cfg_wdata_i,
  input  logic [1:0]  func_i,
  input  logic [3:0]  flow_slot_i,
  input  logic [62:0] now_ns_i,
  input  logic [15:0] packet_size_i,
  input  logic [39:0] latency_ns_i,
  input  logic [31:0] cwnd_i,
  input  logic [39:0] rtt_ns_i,
  output logic        done_o,
  output logic        reportable_o,
  output logic [47:0] mean_datarate_o,
  output logic [31:0] ca_sqr_o,
  output logic [31:0] cs_sqr_o,
  output logic [23:0] mean_packet_size_o,
  output logic [31:0] tx_packets_o,
  output logic [47:0] tx_bytes_o,
  output logic [31:0] rx_packets_o,
  output logic [47:0] rx_bytes_o,
  output logic [39:0] mean_cwnd_o,
  output logic [39:0] mean_rtt_o,
  output logic [39:0] mean_latency_o
);

  cmd_t cmd;
  sts_t sts;

  // sequence table updates and the close-event jobs
  pfts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // hold the flow table, the multiplier, the divider and the result word
  pfts_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .func_i             (func_i),
    .flow_slot_i        (flow_slot_i),
    .now_ns_i           (now_ns_i),
    .packet_size_i      (packet_size_i),
    .latency_ns_i       (latency_ns_i),
    .cwnd_i             (cwnd_i),
    .rtt_ns_i           (rtt_ns_i),
    .done_o             (done_o),
    .reportable_o       (reportable_o),
    .mean_datarate_o    (mean_datarate_o),
    .ca_sqr_o           (ca_sqr_o),
    .cs_sqr_o           (cs_sqr_o),
    .mean_packet_size_o (mean_packet_size_o),
    .tx_packets_o       (tx_packets_o),
    .tx_bytes_o         (tx_bytes_o),
    .rx_packets_o       (rx_packets_o),
    .rx_bytes_o         (rx_bytes_o),
    .mean_cwnd_o        (mean_cwnd_o),
    .mean_rtt_o         (mean_rtt_o),
    .mean_latency_o     (mean_latency_o)
  );

endmodule

FILE: src/pfts_checker.sv
`include "per_flow_traffic_statistics_assert.svh"

module pfts_checker import pfts_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  func_i,
  input logic        done_o,
  input logic        reportable_o,
  input logic [31:0] tx_packets_o
);

  `PFTS_ASSERT_NOW(a_done_when_idle, clk_i, rst_ni, done_o, !busy_o)
  `PFTS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `PFTS_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, done_o, !done_o)
  `PFTS_ASSERT_NEXT(a_update_silent, clk_i, rst_ni, start_i && !busy_o && func_i != FUNC_CLOSE, !done_o)
  `PFTS_ASSERT_NOW(a_reportable, clk_i, rst_ni, done_o, reportable_o == (tx_packets_o > 32'd1))

endmodule

bind per_flow_traffic_statistics pfts_checker u_pfts_checker (.*);

FILE: test/per_flow_traffic_statistics_tb.sv
module per_flow_traffic_statistics_tb;
  import pfts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One flow-statistics result word, as the block reports it on close.
  typedef struct {
    logic        reportable;
    logic [47:0] mean_datarate;
    logic [31:0] ca_sqr;
    logic [31:0] cs_sqr;
    logic [23:0] mean_packet_size;
    logic [31:0] tx_packets;
    logic [47:0] tx_bytes;
    logic [31:0] rx_packets;
    logic [47:0] rx_bytes;
    logic [39:0] mean_cwnd;
    logic [39:0] mean_rtt;
    logic [39:0] mean_latency;
  } flow_report_t;

  localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAX40 = 64'h0000_00FF_FFFF_FFFF;
  localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MAX24 = 64'h0000_0000_00FF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        cfg_we_i = 1'b0;
  logic [39:0] cfg_wdata_i = '0;
  logic [1:0]  func_i = FUNC_TX;
  logic [3:0]  flow_slot_i = '0;
  logic [62:0] now_ns_i = '0;
  logic [15:0] packet_size_i = '0;
  logic [39:0] latency_ns_i = '0;
  logic [31:0] cwnd_i = '0;
  logic [39:0] rtt_ns_i = '0;
  logic        done_o;
  flow_report_t got;

  per_flow_traffic_statistics dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_wdata_i,
    .func_i, .flow_slot_i, .now_ns_i, .packet_size_i, .latency_ns_i,
    .cwnd_i, .rtt_ns_i, .done_o,
    .reportable_o(got.reportable), .mean_datarate_o(got.mean_datarate),
    .ca_sqr_o(got.ca_sqr), .cs_sqr_o(got.cs_sqr),
    .mean_packet_size_o(got.mean_packet_size), .tx_packets_o(got.tx_packets),
    .tx_bytes_o(got.tx_bytes), .rx_packets_o(got.rx_packets),
    .rx_bytes_o(got.rx_bytes), .mean_cwnd_o(got.mean_cwnd),
    .mean_rtt_o(got.mean_rtt), .mean_latency_o(got.mean_latency)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the window register and of every slot's accumulators.
  logic [39:0] window_len = WINDOW_RST;
  logic [63:0] sz_sum [FLOW_SLOTS], sz_sq [FLOW_SLOTS], tx_cnt [FLOW_SLOTS];
  logic [63:0] gp_sum [FLOW_SLOTS], gp_sq [FLOW_SLOTS], last_t [FLOW_SLOTS];
  logic [63:0] lat_sum [FLOW_SLOTS], lat_cnt [FLOW_SLOTS];
  logic [63:0] rx_byt [FLOW_SLOTS], rx_cnt [FLOW_SLOTS];
  logic [63:0] cw_sum [FLOW_SLOTS], rtt_sum [FLOW_SLOTS], smp_cnt [FLOW_SLOTS];

  flow_report_t pending_reports [$];
  int          errors = 0;
  bit          idle_on = 1'b1;
  logic [62:0] flow_clock [FLOW_SLOTS];

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] max);
    if (a > max) a = max;
    if (b > max - a) return max;
    return a + b;
  endfunction

  // floor(num/den) capped at max; zero divisor gives 0
  function automatic logic [63:0] capped_quot(logic [255:0] num, logic [255:0] den,
                                              logic [63:0] max);
    logic [255:0] q;
    if (den == 0) return 0;
    q = num / den;
    return (q > {192'd0, max}) ? max : q[63:0];
  endfunction

  function automatic logic [63:0] scaled_mean(logic [63:0] sum, logic [63:0] scale,
                                              logic [63:0] cnt, logic [63:0] unit_div,
                                              logic [63:0] max);
    if (cnt == 0) return 0;
    return capped_quot({192'd0, sum} * {192'd0, scale}, {192'd0, cnt} * {192'd0, unit_div},
                       max);
  endfunction

  // Squared coefficient of variation, Q16.16, from n values with sum s and square sum q.
  function automatic logic [63:0] sq_variation(logic [63:0] s, logic [63:0] q, logic [63:0] n);
    logic [255:0] nq, ss;
    if (n < 2 || s == 0) return 0;
    nq = {192'd0, n} * {192'd0, q};
    ss = {192'd0, s} * {192'd0, s};
    if (nq <= ss) return 0;
    return capped_quot((nq - ss) * {192'd0, n} * 256'd65536, {192'd0, n - 64'd1} * ss, MAX32);
  endfunction

  task automatic clear_flow(int k);
    sz_sum[k] = 0; sz_sq[k] = 0; tx_cnt[k] = 0; gp_sum[k] = 0; gp_sq[k] = 0;
    last_t[k] = 0; lat_sum[k] = 0; lat_cnt[k] = 0; rx_byt[k] = 0; rx_cnt[k] = 0;
    cw_sum[k] = 0; rtt_sum[k] = 0; smp_cnt[k] = 0;
  endtask

  // Advance the shadow state by one accepted word; queue the report on close.
  task automatic account_event(logic [1:0] fn, int k, logic [62:0] now, logic [15:0] size,
                               logic [39:0] lat, logic [31:0] cw, logic [39:0] rtt);
    logic [63:0] sz, gap, gsq, n;
    flow_report_t r;
    sz = {48'd0, size} + 64'd2;
    case (fn)
      FUNC_TX: begin
        sz_sum[k] = sat_sum(sz_sum[k], sz, MAX48);
        sz_sq[k] = sat_sum(sz_sq[k], sz * sz, ALL64);
        tx_cnt[k] = sat_sum(tx_cnt[k], 1, MAX32);
        if (tx_cnt[k] > 1) begin
          gap = ({1'b0, now} >= last_t[k]) ? {1'b0, now} - last_t[k] : 64'd0;
          gsq = (gap > MAX32) ? ALL64 : gap * gap;
          gp_sum[k] = sat_sum(gp_sum[k], gap, ALL64);
          gp_sq[k] = sat_sum(gp_sq[k], gsq, ALL64);
        end
        last_t[k] = {1'b0, now};
      end
      FUNC_RX: begin
        lat_sum[k] = sat_sum(lat_sum[k], {24'd0, lat}, ALL64);
        lat_cnt[k] = sat_sum(lat_cnt[k], 1, MAX32);
        rx_byt[k] = sat_sum(rx_byt[k], sz, MAX48);
        rx_cnt[k] = sat_sum(rx_cnt[k], 1, MAX32);
      end
      FUNC_SMP: begin
        cw_sum[k] = sat_sum(cw_sum[k], {32'd0, cw}, ALL64);
        rtt_sum[k] = sat_sum(rtt_sum[k], {24'd0, rtt}, ALL64);
        smp_cnt[k] = sat_sum(smp_cnt[k], 1, MAX32);
      end
      default: begin
        n = tx_cnt[k];
        r.reportable = (n >= 2);
        r.mean_datarate = 48'(scaled_mean(sz_sum[k], 64'd524288000, {24'd0, window_len}, 1,
                                          MAX48));
        r.ca_sqr = 32'(sq_variation(gp_sum[k], gp_sq[k], (n >= 1) ? n - 1 : 0));
        r.cs_sqr = 32'(sq_variation(sz_sum[k], sz_sq[k], n));
        r.mean_packet_size = 24'(scaled_mean(sz_sum[k], 256, n, 1, MAX24));
        r.tx_packets = n[31:0];
        r.tx_bytes = sz_sum[k][47:0];
        r.rx_packets = rx_cnt[k][31:0];
        r.rx_bytes = rx_byt[k][47:0];
        r.mean_cwnd = 40'(scaled_mean(cw_sum[k], 256, smp_cnt[k], 1, MAX40));
        r.mean_rtt = 40'(scaled_mean(rtt_sum[k], 65536, smp_cnt[k], 1000000, MAX40));
        r.mean_latency = 40'(scaled_mean(lat_sum[k], 65536, lat_cnt[k], 1000000, MAX40));
        pending_reports.insert(pending_reports.size(), r);
        clear_flow(k);
      end
    endcase
  endtask

  task automatic field_check(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare each report word against the oldest expectation.
  always @(posedge clk_i) begin
    flow_report_t e;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected report word, expected none actual %0h", $realtime,
                 got.tx_bytes);
        errors++;
      end else begin
        e = pending_reports.pop_front();
        field_check("reportable", e.reportable, got.reportable);
        field_check("mean_datarate", e.mean_datarate, got.mean_datarate);
        field_check("ca_sqr", e.ca_sqr, got.ca_sqr);
        field_check("cs_sqr", e.cs_sqr, got.cs_sqr);
        field_check("mean_packet_size", e.mean_packet_size, got.mean_packet_size);
        field_check("tx_packets", e.tx_packets, got.tx_packets);
        field_check("tx_bytes", e.tx_bytes, got.tx_bytes);
        field_check("rx_packets", e.rx_packets, got.rx_packets);
        field_check("rx_bytes", e.rx_bytes, got.rx_bytes);
        field_check("mean_cwnd", e.mean_cwnd, got.mean_cwnd);
        field_check("mean_rtt", e.mean_rtt, got.mean_rtt);
        field_check("mean_latency", e.mean_latency, got.mean_latency);
      end
    end
  end

  // Send one event word; hold start until the block takes it.
  task automatic send_event(logic [1:0] fn, int k, logic [62:0] now, logic [15:0] size,
                            logic [39:0] lat, logic [31:0] cw, logic [39:0] rtt);
    if (idle_on && $urandom_range(99) < 6) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    func_i <= fn;
    flow_slot_i <= k[3:0];
    now_ns_i <= now;
    packet_size_i <= size;
    latency_ns_i <= lat;
    cwnd_i <= cw;
    rtt_ns_i <= rtt;
    do @(posedge clk_i); while (busy_o);
    account_event(fn, k, now, size, lat, cw, rtt);
  endtask

  // Drop start and wait until every report is in and the block has gone quiet.
  task automatic drain;
    @(negedge clk_i);
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0 || busy_o);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_window(logic [39:0] len);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    window_len = len;
  endtask

  task automatic test_extremes;
    // full-scale sizes, latency, window and rtt on one slot
    send_event(FUNC_TX, 0, 63'd0, 16'd0, '0, '0, '0);
    send_event(FUNC_TX, 0, 63'd1000, 16'd65533, '0, '0, '0);
    send_event(FUNC_TX, 0, 63'd1500, 16'd1500, '0, '0, '0);
    send_event(FUNC_RX, 0, '0, 16'd65533, 40'hFF_FFFF_FFFF, '0, '0);
    send_event(FUNC_RX, 0, '0, 16'd0, 40'd0, '0, '0);
    send_event(FUNC_SMP, 0, '0, '0, '0, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
    send_event(FUNC_SMP, 0, '0, '0, '0, 32'd0, 40'd1);
    send_event(FUNC_CLOSE, 0, '0, '0, '0, '0, '0);
    // empty slot and single arrival give zero means and coefficients
    send_event(FUNC_CLOSE, 1, '0, '0, '0, '0, '0);
    send_event(FUNC_TX, 15, 63'd77, 16'd64, '0, '0, '0);
    send_event(FUNC_CLOSE, 15, '0, '0, '0, '0, '0);
  endtask

  task automatic test_time_and_overflow;
    // time going back gives a zero gap; equal sizes give zero size variation
    send_event(FUNC_TX, 2, 63'd5000, 16'd100, '0, '0, '0);
    send_event(FUNC_TX, 2, 63'd4000, 16'd100, '0, '0, '0);
    send_event(FUNC_TX, 2, 63'd4100, 16'd100, '0, '0, '0);
    send_event(FUNC_CLOSE, 2, '0, '0, '0, '0, '0);
    // huge gaps saturate the gap square and its sum
    send_event(FUNC_TX, 3, 63'd0, 16'd9000, '0, '0, '0);
    send_event(FUNC_TX, 3, {1'b1, 62'd0}, 16'd9000, '0, '0, '0);
    send_event(FUNC_TX, 3, {63{1'b1}}, 16'd10, '0, '0, '0);
    send_event(FUNC_CLOSE, 3, '0, '0, '0, '0, '0);
  endtask

  task automatic test_window_extremes;
    set_window(40'd1);
    send_event(FUNC_TX, 4, 63'd1, 16'd65533, '0, '0, '0);
    send_event(FUNC_CLOSE, 4, '0, '0, '0, '0, '0);
    set_window(40'hFF_FFFF_FFFF);
    send_event(FUNC_TX, 4, 63'd1, 16'd65533, '0, '0, '0);
    send_event(FUNC_CLOSE, 4, '0, '0, '0, '0, '0);
    // zero window: the rate reads 0
    set_window(40'd0);
    send_event(FUNC_TX, 4, 63'd1, 16'd500, '0, '0, '0);
    send_event(FUNC_CLOSE, 4, '0, '0, '0, '0, '0);
  endtask

  // Mostly well-formed traffic: per-flow clocks that advance, with closes now and then.
  task automatic test_random_traffic(int count, logic [39:0] len);
    int k, pick;
    logic [62:0] now;
    set_window(len);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, FLOW_SLOTS - 1);
      pick = $urandom_range(99);
      if ($urandom_range(99) < 5) now = 63'({$urandom, $urandom});
      else now = flow_clock[k] + $urandom_range(1, 20000);
      flow_clock[k] = now;
      if (pick < 50)
        send_event(FUNC_TX, k, now, ($urandom_range(9) == 0) ? 16'($urandom_range(0, 65533))
                   : 16'($urandom_range(40, 1500)), '0, '0, '0);
      else if (pick < 70)
        send_event(FUNC_RX, k, now, 16'($urandom_range(0, 65533)),
                   40'({$urandom, $urandom} & MAX40), '0, '0);
      else if (pick < 90)
        send_event(FUNC_SMP, k, now, 16'($urandom_range(0, 65533)), '0, $urandom,
                   ($urandom_range(3) == 0) ? 40'({$urandom, $urandom} & MAX40)
                   : 40'($urandom_range(1000, 5000000)));
      else
        send_event(FUNC_CLOSE, k, 63'({$urandom, $urandom}), 16'($urandom_range(0, 65533)),
                   40'({$urandom, $urandom} & MAX40), $urandom,
                   40'({$urandom, $urandom} & MAX40));
    end
  endtask

  initial begin
    #100ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    for (int k = 0; k < FLOW_SLOTS; k++) begin
      clear_flow(k);
      flow_clock[k] = '0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_time_and_overflow();
    test_window_extremes();
    test_random_traffic(370, WINDOW_RST);
    // keep the sender busy without gaps for a whole phase
    idle_on = 1'b0;
    test_random_traffic(370, 40'd1000);
    idle_on = 1'b1;
    test_random_traffic(370, {8'($urandom_range(255)), $urandom});
    test_random_traffic(370, 40'hFF_FFFF_FFFF);
    test_random_traffic(370, 40'd1);
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
